### rtl/rntt_pkg.sv
package rntt_pkg;

  // Widths fixed by the data format.
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned BASE_W   = 5;
  localparam int unsigned FLAGS_W  = 2;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Quotient bits produced per divider cycle.
  localparam int unsigned DIV_BITS  = 2;
  localparam int unsigned DIV_STEPS = VALUE_W / DIV_BITS;

  // Radix limits.
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd3;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_FLAGS = 2'd1;

  // Format flag bit positions.
  localparam int unsigned FLAG_UNSIGNED = 0;
  localparam int unsigned FLAG_LOWER    = 1;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

  // Status from the divider to the sequencer.
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  // Map one digit to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else if (lower) begin
      digit_char = CHAR_LOWER_A + ext - 7'd10;
    end else begin
      digit_char = CHAR_UPPER_A + ext - 7'd10;
    end
  endfunction

endpackage

### rtl/radix_number_to_text_unit.sv
// Each digit is made by one run of the 2-bit-per-cycle divider, and its
// remainder is stored in the digit memory; then a minus sign, if any, is
// emitted, and each digit is read from the memory and emitted, most significant
// first. One number at a time: the input stalls until the sequencer is idle.
// Reset (synchronous, active low) sets base 10, signed uppercase format and
// an idle sequencer; the digit memory is not cleared.
module radix_number_to_text_unit #(
  parameter int unsigned DIGIT_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration port
  input  logic                                  cfg_we,
  input  logic [rntt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rntt_pkg::BASE_W-1:0]           cfg_wdata,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rntt_pkg::VALUE_W-1:0]   in_value,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rntt_pkg::CHAR_W-1:0]           out_character,
  output logic                                  out_last_char
);

  localparam int unsigned AW = $clog2(DIGIT_DEPTH);
  localparam int unsigned CW = $clog2(DIGIT_DEPTH + 1);

  // Configuration registers.
  logic [rntt_pkg::BASE_W-1:0]  number_base_r;
  logic [rntt_pkg::FLAGS_W-1:0] format_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r  <= 5'd10;
      format_flags_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rntt_pkg::REG_NUMBER_BASE:  number_base_r  <= cfg_wdata;
        rntt_pkg::REG_FORMAT_FLAGS: format_flags_r <= cfg_wdata[rntt_pkg::FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and per-number registers.
  rntt_pkg::state_t             state_r, state_nxt;
  logic [rntt_pkg::VALUE_W-1:0] mag_r, mag_nxt;
  logic [rntt_pkg::BASE_W-1:0]  base_r, base_nxt;
  logic                         neg_r, neg_nxt;
  logic                         lower_r, lower_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;

  // Output register.
  logic                         out_valid_r;
  logic [rntt_pkg::CHAR_W-1:0]  out_character_r;
  logic                         out_last_char_r;
  logic                         out_load;
  logic [rntt_pkg::CHAR_W-1:0]  load_char;
  logic                         load_last;
  logic                         out_free;

  // Digit memory.
  logic [rntt_pkg::DIGIT_W-1:0] digit_mem [DIGIT_DEPTH];
  logic [rntt_pkg::DIGIT_W-1:0] rd_data_r;
  logic                         mem_we;
  logic                         mem_re;

  // Divider.
  logic                         div_start;
  logic [rntt_pkg::VALUE_W-1:0] div_quot;
  rntt_pkg::div_status_t        div_st;

  logic [rntt_pkg::BASE_W-1:0]  base_sat;
  logic                         value_neg;
  logic [CW-1:0]                cnt_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_inc   = cnt_r + 1'b1;
  assign value_neg = !format_flags_r[rntt_pkg::FLAG_UNSIGNED] && in_value[rntt_pkg::VALUE_W-1];

  // Clamp the radix into its supported range.
  always_comb begin
    if (number_base_r < rntt_pkg::BASE_MIN) begin
      base_sat = rntt_pkg::BASE_MIN;
    end else if (number_base_r > rntt_pkg::BASE_MAX) begin
      base_sat = rntt_pkg::BASE_MAX;
    end else begin
      base_sat = number_base_r;
    end
  end

  rntt_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (base_r),
    .quotient (div_quot),
    .status   (div_st)
  );

  // Next state and control.
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    lower_nxt = lower_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    load_char = rntt_pkg::digit_char(rd_data_r, lower_r);
    load_last = 1'b0;
    case (state_r)
      rntt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          neg_nxt   = value_neg;
          mag_nxt   = value_neg ? (64'd0 - $unsigned(in_value)) : $unsigned(in_value);
          base_nxt  = base_sat;
          lower_nxt = format_flags_r[rntt_pkg::FLAG_LOWER];
          cnt_nxt   = '0;
          state_nxt = rntt_pkg::ST_LAUNCH;
        end
      end
      rntt_pkg::ST_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = rntt_pkg::ST_DIVIDE;
      end
      rntt_pkg::ST_DIVIDE: begin
        if (div_st.done) begin
          mem_we  = 1'b1;
          mag_nxt = div_quot;
          cnt_nxt = cnt_inc;
          if (div_quot != '0 && cnt_inc < CW'(DIGIT_DEPTH)) begin
            state_nxt = rntt_pkg::ST_LAUNCH;
          end else begin
            state_nxt = rntt_pkg::ST_SIGN;
          end
        end
      end
      rntt_pkg::ST_SIGN: begin
        mag_nxt = '0;
        idx_nxt = AW'(cnt_r - 1'b1);
        if (!neg_r) begin
          state_nxt = rntt_pkg::ST_READ;
        end else if (out_free) begin
          out_load  = 1'b1;
          load_char = rntt_pkg::CHAR_MINUS;
          state_nxt = rntt_pkg::ST_READ;
        end
      end
      rntt_pkg::ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = rntt_pkg::ST_EMIT;
      end
      rntt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_last = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = rntt_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = rntt_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = rntt_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rntt_pkg::ST_IDLE;
      mag_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mag_r   <= mag_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Per-number payload registers.
  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    neg_r   <= neg_nxt;
    lower_r <= lower_nxt;
    idx_r   <= idx_nxt;
  end

  // Digit memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[AW-1:0]] <= div_st.remainder;
    end
    if (mem_re) begin
      rd_data_r <= digit_mem[idx_r];
    end
  end

  // Output register: a new character loads as the old one transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_character_r <= load_char;
      out_last_char_r <= load_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last_char = out_last_char_r;

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == rntt_pkg::ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> cnt_r < CW'(DIGIT_DEPTH))
    else $error("digit write beyond memory depth");

  a_digits_present: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rntt_pkg::ST_SIGN |-> cnt_r != '0)
    else $error("emission started with no digits");

  a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && load_last) |=> state_r == rntt_pkg::ST_IDLE && out_valid_r)
    else $error("final character did not end the number");

endmodule

### rtl/rntt_divider.sv
// Restoring divider of a 64-bit magnitude by a small radix, two quotient
// bits per cycle.
module rntt_divider (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [rntt_pkg::VALUE_W-1:0]         dividend,
  input  logic [rntt_pkg::BASE_W-1:0]          divisor,
  output logic [rntt_pkg::VALUE_W-1:0]         quotient,
  output rntt_pkg::div_status_t                status
);

  localparam int unsigned CNT_W = $clog2(rntt_pkg::DIV_STEPS);

  logic [rntt_pkg::VALUE_W-1:0] q_r, q_nxt;
  logic [rntt_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;

  // Shift-subtract steps for one cycle.
  always_comb begin
    logic [rntt_pkg::DIGIT_W:0] trial;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < rntt_pkg::DIV_BITS; k++) begin
      trial = {rem_nxt, q_nxt[rntt_pkg::VALUE_W-1]};
      q_nxt = {q_nxt[rntt_pkg::VALUE_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_nxt  = rntt_pkg::DIGIT_W'(trial - divisor);
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = rntt_pkg::DIGIT_W'(trial);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(rntt_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in from the bottom as the dividend leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient         = q_r;
  assign status.done      = done_r;
  assign status.remainder = rem_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < divisor))
    else $error("remainder not below divisor");

endmodule
